>>> rtl/core/rpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_pkg: shared definitions for the RGBA pixel clamp
// Channel indices, register map codes and the mode flag group.
// ----------------------------------------------------------------------------
package rpc_pkg;

	localparam int NUM_CH    = 4;
	localparam int REG_IDX_W = 3;

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;
	localparam logic [1:0] CH_ALPHA = 2'd3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_INVERT_MODE    = 3'd0,
		REG_FLOOR_ENABLE   = 3'd1,
		REG_CEILING_ENABLE = 3'd2,
		REG_FLOOR_LEVEL    = 3'd3,
		REG_CEILING_LEVEL  = 3'd4
	} rpc_reg_t;

	typedef struct packed {
		logic invert_mode;
		logic floor_enable;
		logic ceiling_enable;
	} rpc_mode_t;

endpackage

>>> rtl/core/rpc_pixel_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_pixel_if: pixel stream channels
// Valid/ready channels carrying one RGBA word, input and output flavours.
// ----------------------------------------------------------------------------
interface rpc_pixel_in_if #(parameter int COMP_WIDTH = 32);
	logic                         valid;
	logic                         ready;
	logic signed [COMP_WIDTH-1:0] red_in;
	logic signed [COMP_WIDTH-1:0] green_in;
	logic signed [COMP_WIDTH-1:0] blue_in;
	logic signed [COMP_WIDTH-1:0] alpha_in;

	modport source (output valid, output red_in, output green_in, output blue_in,
		output alpha_in, input ready);
	modport sink (input valid, input red_in, input green_in, input blue_in,
		input alpha_in, output ready);
endinterface

interface rpc_pixel_out_if #(parameter int COMP_WIDTH = 32);
	logic                         valid;
	logic                         ready;
	logic signed [COMP_WIDTH-1:0] red_out;
	logic signed [COMP_WIDTH-1:0] green_out;
	logic signed [COMP_WIDTH-1:0] blue_out;
	logic signed [COMP_WIDTH-1:0] alpha_out;

	modport source (output valid, output red_out, output green_out, output blue_out,
		output alpha_out, input ready);
	modport sink (input valid, input red_out, input green_out, input blue_out,
		input alpha_out, output ready);
endinterface

>>> rtl/core/rgba_pixel_clamp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgba_pixel_clamp: RGBA fixed point clamp
// Clamps one signed fixed point RGBA word per clock while pix_out does not stall.
// ----------------------------------------------------------------------------
// pix_in takes a word whenever valid and ready are both high; pix_out shows
// the clamped word until the receiver takes it. The user must see that the
// registers are written over the APB port only while the pipeline is empty;
// the block itself does not enforce this. From acceptance to pix_out.valid a
// word passes the negate, red, green and blue steps, then ceiling and the
// zero-alpha override, one register stage each. Throughput is one word per
// cycle while pix_out does not stall; the red/green/blue steps form a
// dependent chain of saturating subtracts, one channel per stage. Each stage
// loads when it is empty or the stage after it loads, so a stall at pix_out
// backs up one stage at a time and bubbles are squeezed out; pix_in.ready
// stays high while any stage is empty. Nothing is lost or repeated under stall.
// Reset clears all stage valid bits and returns the registers to their
// defaults (floor 0, ceiling 1.0, floor and ceiling clamps on).
// ----------------------------------------------------------------------------
module rgba_pixel_clamp #(
	parameter int COMP_WIDTH = 32,
	parameter int FRAC_BITS  = 16,
	localparam int APB_DATA_W = (COMP_WIDTH > 32) ? 64 : 32,
	localparam int APB_ADDR_W = rpc_pkg::REG_IDX_W + ((APB_DATA_W == 64) ? 3 : 2)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rpc_pixel_in_if.sink          pix_in,
	rpc_pixel_out_if.source       pix_out,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);
	import rpc_pkg::*;

	typedef logic [NUM_CH-1:0][COMP_WIDTH-1:0] pix_t;

	rpc_mode_t                    mode;
	logic signed [COMP_WIDTH-1:0] floor_level;
	logic signed [COMP_WIDTH-1:0] ceiling_level;

	pix_t pix_in_w, neg_pix, red_pix, green_pix, blue_pix, ceil_pix;
	logic neg_zero;

	logic load1, load2, load3, load4, load5;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic zero_s1, zero_s2, zero_s3, zero_s4;
	pix_t pix_s1, pix_s2, pix_s3, pix_s4, pix_s5;

	rpc_cfg_regs #(
		.COMP_WIDTH (COMP_WIDTH),
		.FRAC_BITS  (FRAC_BITS),
		.APB_DATA_W (APB_DATA_W),
		.APB_ADDR_W (APB_ADDR_W)
	) u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.mode          (mode),
		.floor_level   (floor_level),
		.ceiling_level (ceiling_level)
	);

	assign pix_in_w[CH_RED]   = pix_in.red_in;
	assign pix_in_w[CH_GREEN] = pix_in.green_in;
	assign pix_in_w[CH_BLUE]  = pix_in.blue_in;
	assign pix_in_w[CH_ALPHA] = pix_in.alpha_in;

	// advance a stage when it is empty or its successor advances
	assign load5 = !valid_s5 || pix_out.ready;
	assign load4 = !valid_s4 || load5;
	assign load3 = !valid_s3 || load4;
	assign load2 = !valid_s2 || load3;
	assign load1 = !valid_s1 || load2;

	assign pix_in.ready = load1;

	rpc_negate #(.COMP_WIDTH(COMP_WIDTH)) u_negate (
		.mode        (mode),
		.floor_level (floor_level),
		.pix         (pix_in_w),
		.pix_o       (neg_pix),
		.zero        (neg_zero)
	);

	rpc_redist #(.COMP_WIDTH(COMP_WIDTH)) u_red (
		.mode        (mode),
		.floor_level (floor_level),
		.ch          (CH_RED),
		.pix         (pix_s1),
		.pix_o       (red_pix)
	);

	rpc_redist #(.COMP_WIDTH(COMP_WIDTH)) u_green (
		.mode        (mode),
		.floor_level (floor_level),
		.ch          (CH_GREEN),
		.pix         (pix_s2),
		.pix_o       (green_pix)
	);

	rpc_redist #(.COMP_WIDTH(COMP_WIDTH)) u_blue (
		.mode        (mode),
		.floor_level (floor_level),
		.ch          (CH_BLUE),
		.pix         (pix_s3),
		.pix_o       (blue_pix)
	);

	rpc_ceiling #(.COMP_WIDTH(COMP_WIDTH)) u_ceiling (
		.mode          (mode),
		.ceiling_level (ceiling_level),
		.zero          (zero_s4),
		.pix           (pix_s4),
		.pix_o         (ceil_pix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (load1) valid_s1 <= pix_in.valid;
			if (load2) valid_s2 <= valid_s1;
			if (load3) valid_s3 <= valid_s2;
			if (load4) valid_s4 <= valid_s3;
			if (load5) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (load1) begin
			pix_s1  <= neg_pix;
			zero_s1 <= neg_zero;
		end
		if (load2) begin
			pix_s2  <= red_pix;
			zero_s2 <= zero_s1;
		end
		if (load3) begin
			pix_s3  <= green_pix;
			zero_s3 <= zero_s2;
		end
		if (load4) begin
			pix_s4  <= blue_pix;
			zero_s4 <= zero_s3;
		end
		if (load5)
			pix_s5 <= ceil_pix;
	end

	assign pix_out.valid     = valid_s5;
	assign pix_out.red_out   = pix_s5[CH_RED];
	assign pix_out.green_out = pix_s5[CH_GREEN];
	assign pix_out.blue_out  = pix_s5[CH_BLUE];
	assign pix_out.alpha_out = pix_s5[CH_ALPHA];

endmodule

>>> rtl/core/rpc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_cfg_regs: APB register file
// Holds mode flags and the floor and ceiling levels; always ready.
// ----------------------------------------------------------------------------
module rpc_cfg_regs #(
	parameter int COMP_WIDTH = 32,
	parameter int FRAC_BITS  = 16,
	parameter int APB_DATA_W = 32,
	parameter int APB_ADDR_W = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [APB_ADDR_W-1:0]        paddr,
	input  logic [APB_DATA_W-1:0]        pwdata,
	output logic [APB_DATA_W-1:0]        prdata,
	output logic                         pready,
	output rpc_pkg::rpc_mode_t           mode,
	output logic signed [COMP_WIDTH-1:0] floor_level,
	output logic signed [COMP_WIDTH-1:0] ceiling_level
);
	import rpc_pkg::*;

	localparam logic [COMP_WIDTH-1:0] CEIL_RESET = COMP_WIDTH'(1) << FRAC_BITS;

	rpc_mode_t             mode_q;
	logic [COMP_WIDTH-1:0] floor_q;
	logic [COMP_WIDTH-1:0] ceiling_q;
	rpc_reg_t              reg_idx;
	logic                  wr_en;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = rpc_reg_t'(paddr[APB_ADDR_W-1 -: REG_IDX_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q.invert_mode    <= 1'b0;
			mode_q.floor_enable   <= 1'b1;
			mode_q.ceiling_enable <= 1'b1;
			floor_q               <= '0;
			ceiling_q             <= CEIL_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_INVERT_MODE:    mode_q.invert_mode    <= pwdata[0];
				REG_FLOOR_ENABLE:   mode_q.floor_enable   <= pwdata[0];
				REG_CEILING_ENABLE: mode_q.ceiling_enable <= pwdata[0];
				REG_FLOOR_LEVEL:    floor_q               <= pwdata[COMP_WIDTH-1:0];
				REG_CEILING_LEVEL:  ceiling_q             <= pwdata[COMP_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_INVERT_MODE:    prdata = APB_DATA_W'(mode_q.invert_mode);
			REG_FLOOR_ENABLE:   prdata = APB_DATA_W'(mode_q.floor_enable);
			REG_CEILING_ENABLE: prdata = APB_DATA_W'(mode_q.ceiling_enable);
			REG_FLOOR_LEVEL:    prdata = APB_DATA_W'(floor_q);
			REG_CEILING_LEVEL:  prdata = APB_DATA_W'(ceiling_q);
			default:            prdata = '0;
		endcase
	end

	assign mode          = mode_q;
	assign floor_level   = $signed(floor_q);
	assign ceiling_level = $signed(ceiling_q);

endmodule

>>> rtl/core/rpc_negate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_negate: first stage logic
// Flags zero alpha and negates the whole word when alpha sits below the floor
// in invert mode, saturating the most negative value.
// ----------------------------------------------------------------------------
module rpc_negate #(
	parameter int COMP_WIDTH = 32
) (
	input  rpc_pkg::rpc_mode_t                                 mode,
	input  logic signed [COMP_WIDTH-1:0]                       floor_level,
	input  logic [rpc_pkg::NUM_CH-1:0][COMP_WIDTH-1:0]         pix,
	output logic [rpc_pkg::NUM_CH-1:0][COMP_WIDTH-1:0]         pix_o,
	output logic                                               zero
);
	import rpc_pkg::*;

	localparam logic [COMP_WIDTH-1:0] MAX_VAL = {1'b0, {(COMP_WIDTH-1){1'b1}}};
	localparam logic [COMP_WIDTH-1:0] MIN_VAL = {1'b1, {(COMP_WIDTH-1){1'b0}}};

	logic neg_all;

	assign zero    = (pix[CH_ALPHA] == '0);
	assign neg_all = mode.invert_mode && ($signed(pix[CH_ALPHA]) < floor_level);

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			if (!neg_all)
				pix_o[i] = pix[i];
			else if (pix[i] == MIN_VAL)
				pix_o[i] = MAX_VAL;
			else
				pix_o[i] = -pix[i];
		end
	end

endmodule

>>> rtl/core/rpc_redist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_redist: one colour channel step
// In invert mode a channel below the floor is taken from the other two
// colour channels (saturating) and pinned to the floor. With invert mode off
// and floor enable on, the red step also applies the plain floor clamp to all four channels.
// ----------------------------------------------------------------------------
module rpc_redist #(
	parameter int COMP_WIDTH = 32
) (
	input  rpc_pkg::rpc_mode_t                         mode,
	input  logic signed [COMP_WIDTH-1:0]               floor_level,
	input  logic [1:0]                                 ch,
	input  logic [rpc_pkg::NUM_CH-1:0][COMP_WIDTH-1:0] pix,
	output logic [rpc_pkg::NUM_CH-1:0][COMP_WIDTH-1:0] pix_o
);
	import rpc_pkg::*;

	localparam logic [COMP_WIDTH-1:0] MAX_VAL = {1'b0, {(COMP_WIDTH-1){1'b1}}};
	localparam logic [COMP_WIDTH-1:0] MIN_VAL = {1'b1, {(COMP_WIDTH-1){1'b0}}};

	logic [1:0]            idx_a;
	logic [1:0]            idx_b;
	logic [COMP_WIDTH-1:0] cur;

	function automatic logic [COMP_WIDTH-1:0] sat_sub(input logic [COMP_WIDTH-1:0] x,
		input logic [COMP_WIDTH-1:0] y);
		logic [COMP_WIDTH:0] d;
		d = {x[COMP_WIDTH-1], x} - {y[COMP_WIDTH-1], y};
		if (d[COMP_WIDTH] != d[COMP_WIDTH-1])
			sat_sub = d[COMP_WIDTH] ? MIN_VAL : MAX_VAL;
		else
			sat_sub = d[COMP_WIDTH-1:0];
	endfunction

	always_comb begin
		unique case (ch)
			CH_RED: begin
				idx_a = CH_GREEN;
				idx_b = CH_BLUE;
			end
			CH_GREEN: begin
				idx_a = CH_BLUE;
				idx_b = CH_RED;
			end
			default: begin
				idx_a = CH_RED;
				idx_b = CH_GREEN;
			end
		endcase
	end

	assign cur = pix[ch];

	always_comb begin
		pix_o = pix;
		if (mode.invert_mode) begin
			if ($signed(cur) < floor_level) begin
				pix_o[idx_a] = sat_sub(pix[idx_a], cur);
				pix_o[idx_b] = sat_sub(pix[idx_b], cur);
				pix_o[ch]    = floor_level;
			end
		end else if (mode.floor_enable && (ch == CH_RED)) begin
			for (int i = 0; i < NUM_CH; i++) begin
				if ($signed(pix[i]) < floor_level)
					pix_o[i] = floor_level;
			end
		end
	end

endmodule

>>> rtl/core/rpc_ceiling.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_ceiling: final stage logic
// Limits every channel to the ceiling when the ceiling clamp is on, and forces a
// transparent word when the incoming alpha was zero.
// ----------------------------------------------------------------------------
module rpc_ceiling #(
	parameter int COMP_WIDTH = 32
) (
	input  rpc_pkg::rpc_mode_t                         mode,
	input  logic signed [COMP_WIDTH-1:0]               ceiling_level,
	input  logic                                       zero,
	input  logic [rpc_pkg::NUM_CH-1:0][COMP_WIDTH-1:0] pix,
	output logic [rpc_pkg::NUM_CH-1:0][COMP_WIDTH-1:0] pix_o
);
	import rpc_pkg::*;

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			if (zero)
				pix_o[i] = '0;
			else if (mode.ceiling_enable && ($signed(pix[i]) > ceiling_level))
				pix_o[i] = ceiling_level;
			else
				pix_o[i] = pix[i];
		end
	end

endmodule

>>> rtl/core/rpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_checker: port-level checks for the RGBA pixel clamp
// Watches the pixel channels; bound to every instance of the top level.
// ----------------------------------------------------------------------------
module rpc_checker #(
	parameter int COMP_WIDTH = 32
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic [COMP_WIDTH-1:0] in_alpha,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [COMP_WIDTH-1:0] out_red,
	input logic [COMP_WIDTH-1:0] out_green,
	input logic [COMP_WIDTH-1:0] out_blue,
	input logic [COMP_WIDTH-1:0] out_alpha
);

	// a stalled word stays offered
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_red) && $stable(out_green)
			&& $stable(out_blue) && $stable(out_alpha))
		else $error("output word changed while stalled");

	// an empty output stage means every stage can take a word
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output stage");

	// zero alpha on a free-running pipe gives a transparent word at the output
	a_zero_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_alpha == '0) && out_ready
			##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready
		|=> out_valid && (out_red == '0) && (out_green == '0)
			&& (out_blue == '0) && (out_alpha == '0))
		else $error("zero alpha word not transparent after pipeline latency");

endmodule

bind rgba_pixel_clamp rpc_checker #(.COMP_WIDTH(COMP_WIDTH)) u_rpc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix_in.valid),
	.in_ready  (pix_in.ready),
	.in_alpha  (pix_in.alpha_in),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.out_red   (pix_out.red_out),
	.out_green (pix_out.green_out),
	.out_blue  (pix_out.blue_out),
	.out_alpha (pix_out.alpha_out)
);

>>> tb/sv/rpc_clamp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_clamp_checker: output checker for the RGBA pixel clamp
// Follows register writes on the APB port, predicts the clamped word for every
// word taken at pix_in and compares each word leaving pix_out, field by field,
// with the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module rpc_clamp_checker
	import rpc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	rpc_pixel_in_if              pix_in,
	rpc_pixel_out_if             pix_out,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [REG_IDX_W+1:0] paddr,
	input  logic [31:0]          pwdata,
	input  logic                 pready,
	output int                   mismatches,
	output int                   in_flight
);

	typedef struct packed {
		logic [31:0] red;
		logic [31:0] green;
		logic [31:0] blue;
		logic [31:0] alpha;
	} rgba_t;

	localparam longint COMP_MAX = 2147483647;
	localparam longint COMP_MIN = -longint'(2147483647) - 1;

	logic               invert_on;
	logic               floor_on;
	logic               ceiling_on;
	logic signed [31:0] floor_lvl;
	logic signed [31:0] ceiling_lvl;

	rgba_t clamped_fifo[$];

	function automatic longint saturate(longint x);
		if (x > COMP_MAX)
			return COMP_MAX;
		if (x < COMP_MIN)
			return COMP_MIN;
		return x;
	endfunction

	function automatic rgba_t predict_word(rgba_t px);
		longint c[4];
		longint flo;
		longint cei;
		int     i;
		int     a;
		int     b;
		rgba_t  res;
		c[CH_RED]   = longint'($signed(px.red));
		c[CH_GREEN] = longint'($signed(px.green));
		c[CH_BLUE]  = longint'($signed(px.blue));
		c[CH_ALPHA] = longint'($signed(px.alpha));
		flo = longint'(floor_lvl);
		cei = longint'(ceiling_lvl);
		// fully transparent: nothing else applies
		if (c[CH_ALPHA] == 0)
			return '0;
		if (invert_on) begin
			if (c[CH_ALPHA] < flo)
				for (i = 0; i < NUM_CH; i++)
					c[i] = saturate(-c[i]);
			// push each colour's shortfall onto the other two, red first
			for (i = 0; i < 3; i++) begin
				if (c[i] < flo) begin
					a = (i + 1) % 3;
					b = (i + 2) % 3;
					c[a] = saturate(c[a] - c[i]);
					c[b] = saturate(c[b] - c[i]);
					c[i] = flo;
				end
			end
		end else if (floor_on) begin
			for (i = 0; i < NUM_CH; i++)
				if (c[i] < flo)
					c[i] = flo;
		end
		if (ceiling_on)
			for (i = 0; i < NUM_CH; i++)
				if (c[i] > cei)
					c[i] = cei;
		res.red   = c[CH_RED][31:0];
		res.green = c[CH_GREEN][31:0];
		res.blue  = c[CH_BLUE][31:0];
		res.alpha = c[CH_ALPHA][31:0];
		return res;
	endfunction

	function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
		if (want === got)
			return 0;
		$error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rgba_t want;
		rgba_t got;
		int    bad;
		if (!arst_n) begin
			clamped_fifo.delete();
			invert_on   = 1'b0;
			floor_on    = 1'b1;
			ceiling_on  = 1'b1;
			floor_lvl   = '0;
			ceiling_lvl = 32'sh0001_0000;
			mismatches <= 0;
			in_flight  <= 0;
		end else begin
			bad = 0;
			if (pix_out.valid && pix_out.ready) begin
				got = {pix_out.red_out, pix_out.green_out, pix_out.blue_out,
					pix_out.alpha_out};
				if (clamped_fifo.size() == 0) begin
					$error("output word with no input word outstanding");
					bad++;
				end else begin
					want = clamped_fifo.pop_front();
					bad += field_differs("red_out", want.red, got.red);
					bad += field_differs("green_out", want.green, got.green);
					bad += field_differs("blue_out", want.blue, got.blue);
					bad += field_differs("alpha_out", want.alpha, got.alpha);
				end
			end
			// predict with the settings in force before any write at this edge
			if (pix_in.valid && pix_in.ready)
				clamped_fifo.push_back(predict_word({pix_in.red_in, pix_in.green_in,
					pix_in.blue_in, pix_in.alpha_in}));
			if (psel && penable && pwrite && pready) begin
				case (paddr[REG_IDX_W+1:2])
					REG_INVERT_MODE:    invert_on   = pwdata[0];
					REG_FLOOR_ENABLE:   floor_on    = pwdata[0];
					REG_CEILING_ENABLE: ceiling_on  = pwdata[0];
					REG_FLOOR_LEVEL:    floor_lvl   = pwdata;
					REG_CEILING_LEVEL:  ceiling_lvl = pwdata;
					default: ;
				endcase
			end
			mismatches <= mismatches + bad;
			in_flight  <= clamped_fifo.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the RGBA pixel clamp
// Writes the clamp settings over APB, sends directed and random pixel words
// under changing sender gaps and receiver stalls, including one long receiver
// hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
	import rpc_pkg::*;

	localparam int          ADDR_W     = REG_IDX_W + 2;
	localparam int          HOLD_CYCLES = 300;
	localparam logic [2:0]  REG_SPARE  = 3'd7;
	localparam logic [31:0] COMP_MAX   = 32'h7fff_ffff;
	localparam logic [31:0] COMP_MIN   = 32'h8000_0000;
	localparam logic [31:0] ONE_Q16    = 32'h0001_0000;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	int mismatch_count;
	int words_in_flight;
	int sender_gap_pct;
	int receiver_stall_pct;
	bit hold_off_req;

	logic [31:0] floor_now;
	logic [31:0] ceiling_now;

	rpc_pixel_in_if  #(.COMP_WIDTH(32)) pix_in ();
	rpc_pixel_out_if #(.COMP_WIDTH(32)) pix_out ();

	rgba_pixel_clamp dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in),
		.pix_out (pix_out),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	rpc_clamp_checker clamp_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_in     (pix_in),
		.pix_out    (pix_out),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.mismatches (mismatch_count),
		.in_flight  (words_in_flight)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("testbench failed");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		pix_out.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				pix_out.ready <= 1'b0;
				hold_off_req = 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				pix_out.ready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_until_empty();
		pix_in.valid <= 1'b0;
		do @(posedge clk); while (words_in_flight != 0);
	endtask

	task automatic set_config(input bit inv, input bit fe, input bit ce,
		input logic [31:0] flo, input logic [31:0] cei);
		wait_until_empty();
		apb_write(REG_INVERT_MODE, {31'd0, inv});
		apb_write(REG_FLOOR_ENABLE, {31'd0, fe});
		apb_write(REG_CEILING_ENABLE, {31'd0, ce});
		apb_write(REG_FLOOR_LEVEL, flo);
		apb_write(REG_CEILING_LEVEL, cei);
		floor_now   = flo;
		ceiling_now = cei;
	endtask

	task automatic send_pixel(input logic [31:0] r, input logic [31:0] g,
		input logic [31:0] b, input logic [31:0] a);
		while ($urandom_range(99) < sender_gap_pct) begin
			pix_in.valid <= 1'b0;
			@(posedge clk);
		end
		pix_in.valid    <= 1'b1;
		pix_in.red_in   <= r;
		pix_in.green_in <= g;
		pix_in.blue_in  <= b;
		pix_in.alpha_in <= a;
		@(posedge clk);
		while (!pix_in.ready) @(posedge clk);
	endtask

	// many values around the current floor and ceiling, where the clamps bite
	function automatic logic [31:0] pick_comp();
		logic [31:0] lvl;
		lvl = $urandom_range(1) ? floor_now : ceiling_now;
		case ($urandom_range(9))
			0:       return COMP_MIN;
			1:       return COMP_MAX;
			2:       return '0;
			3, 4, 5: return $urandom;
			default: return lvl + $urandom_range(32'h4_0000) - 32'h2_0000;
		endcase
	endfunction

	function automatic logic [31:0] pick_alpha();
		if ($urandom_range(15) == 0)
			return '0;
		return pick_comp();
	endfunction

	initial begin
		int phase;
		int n;
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		pix_in.valid       = 1'b0;
		pix_in.red_in      = '0;
		pix_in.green_in    = '0;
		pix_in.blue_in     = '0;
		pix_in.alpha_in    = '0;
		hold_off_req       = 1'b0;
		sender_gap_pct     = 30;
		receiver_stall_pct = 81;
		floor_now          = '0;
		ceiling_now        = ONE_Q16;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: floor 0, ceiling 1.0
		send_pixel(COMP_MAX, COMP_MIN, 32'd1234, 32'd0);
		send_pixel(COMP_MIN, COMP_MAX, 32'd0, COMP_MAX);
		send_pixel(COMP_MAX, COMP_MIN, COMP_MIN, COMP_MIN);
		send_pixel(32'h0000_8000, 32'hffff_ffff, ONE_Q16, 32'h0001_0001);

		// inversion with no clamps; the spare register address must do nothing
		set_config(1'b1, 1'b0, 1'b0, 32'd0, COMP_MAX);
		apb_write(REG_SPARE, 32'hffff_ffff);
		send_pixel(COMP_MIN, 32'd100, -32'sd5, -32'sd1);
		send_pixel(COMP_MIN, COMP_MAX, 32'd3, ONE_Q16);
		send_pixel(32'd10, -32'sd20, -32'sd30, 32'd5);
		send_pixel(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MIN);
		send_pixel(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, COMP_MAX);

		// floor above ceiling
		set_config(1'b1, 1'b1, 1'b1, ONE_Q16, 32'h0000_8000);
		send_pixel(32'd0, 32'h0002_0000, ONE_Q16, 32'h0001_8000);
		send_pixel(32'h0003_0000, 32'h0000_5000, 32'd0, 32'd1);
		send_pixel(COMP_MIN, COMP_MIN, COMP_MIN, 32'd0);

		set_config(1'b0, 1'b1, 1'b1, COMP_MAX, COMP_MIN);
		send_pixel(32'd0, 32'd1, 32'd2, 32'd3);
		send_pixel(COMP_MIN, COMP_MAX, 32'd0, 32'hffff_ffff);

		set_config(1'b0, 1'b1, 1'b0, COMP_MIN, COMP_MIN);
		send_pixel(COMP_MIN, COMP_MAX, 32'hffff_ffff, 32'd1);

		set_config(1'b0, 1'b0, 1'b0, COMP_MAX, COMP_MIN);
		send_pixel(COMP_MIN, COMP_MAX, 32'h1234_5678, 32'hdead_beef);
		send_pixel(32'd0, 32'd0, 32'd0, 32'd0);

		set_config(1'b1, 1'b0, 1'b1, COMP_MIN, COMP_MAX);
		send_pixel(COMP_MIN, COMP_MIN, COMP_MAX, COMP_MIN);

		for (phase = 0; phase < 9; phase++) begin
			case (phase)
				0: set_config(1'b0, 1'b1, 1'b1, 32'd0, ONE_Q16);
				1: set_config(1'b1, 1'b0, 1'b1, 32'd0, ONE_Q16);
				2: set_config(1'b1, 1'b1, 1'b0, COMP_MIN, COMP_MAX);
				3: set_config(1'b0, 1'b1, 1'b0, COMP_MAX, COMP_MIN);
				4: set_config(1'b1, 1'b1, 1'b1, ONE_Q16, 32'd0);
				default: set_config(phase[0], 1'($urandom_range(1)), 1'($urandom_range(1)),
					$urandom_range(32'h3_0000) - 32'h1_8000,
					$urandom_range(32'h4_0000));
			endcase
			case (phase / 3)
				0: begin
					sender_gap_pct     = 30;
					receiver_stall_pct = 81;
				end
				1: begin
					sender_gap_pct     = 81;
					receiver_stall_pct = 30;
				end
				default: begin
					sender_gap_pct     = 0;
					receiver_stall_pct = 0;
				end
			endcase
			// hold the receiver off while words keep coming, so the pipe backs up
			if (phase == 6)
				hold_off_req = 1'b1;
			for (n = 0; n < 100; n++)
				send_pixel(pick_comp(), pick_comp(), pick_comp(), pick_alpha());
		end

		wait_until_empty();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
